### rtl/tf_pkg.sv
// shared constants and types of the trapezoid fuzzifier
package tf_pkg;

    localparam int NUM_INPUTS = 4;
    localparam int NUM_SETS   = 8;
    localparam int ENTRIES    = NUM_INPUTS * NUM_SETS;
    localparam int ADDR_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int K_W        = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    localparam int PT_W   = 16;
    localparam int Q_W    = 15;
    localparam int CNT_W  = $clog2(Q_W);
    localparam int MEM_W  = 16;
    localparam int SLOT_W = 3;
    localparam int VAR_W  = 2;

    localparam logic [MEM_W-1:0] ONE_Q15 = 16'h8000;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_FUZZ = 1'b1
    } t_op;

    typedef struct packed {
        logic signed [PT_W-1:0] d;
        logic signed [PT_W-1:0] c;
        logic signed [PT_W-1:0] b;
        logic signed [PT_W-1:0] a;
    } t_points;

endpackage

### rtl/tf_ram.sv
// generic single-write, single-read memory with registered read data
module tf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tf_divider.sv
// restoring divider, one quotient bit per cycle, for num < den
module tf_divider import tf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [PT_W-1:0] i_num,
    input  logic [PT_W-1:0] i_den,
    output logic            o_done,
    output logic [Q_W-1:0]  o_quot
);

    logic [PT_W-1:0]  r_rem;
    logic [PT_W-1:0]  r_den;
    logic [Q_W-1:0]   r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [PT_W:0]   w_shift;
    logic [PT_W+1:0] w_diff;
    logic            w_fit;

    assign w_shift = {r_rem, 1'b0};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_den};
    assign w_fit   = ~w_diff[PT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quot <= '0;
                r_cnt  <= CNT_W'(Q_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // remainder stays below the divisor, so it fits the point width
                r_rem  <= w_fit ? w_diff[PT_W-1:0] : w_shift[PT_W-1:0];
                r_quot <= {r_quot[Q_W-2:0], w_fit};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### rtl/trapezoid_fuzzifier.sv
// trapezoid fuzzifier top level: set table, slot sequencer and output register
// A load request writes one trapezoid (a, b, c, d) into the set table in the
// cycle it is accepted and gives no result. A fuzzify request walks the slots
// of its input variable, slot 0 first, and gives one membership result per slot
// in Q1.15, tlast on the final slot. Each slot passes through a table read
// state and an evaluate state, then through a divide state when the value
// lies on a sloped edge and the shared bit-serial divider makes 15 quotient
// bits, then waits in the output register until taken, however long the
// downstream side stalls. No new request is taken while one is in work.
// The table is cleared by reset through per-entry valid bits.
module trapezoid_fuzzifier import tf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // input_index[1:0], set_index[4:2], point_a[20:5], point_b[36:21],
    // point_c[52:37], point_d[68:53], crisp_value[84:69], zero fill above
    input  logic [87:0]  s_axis_tdata,
    // op[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot_index[2:0], membership[18:3], zero fill above
    output logic [23:0]  m_axis_tdata,
    // configured[0]
    output logic [0:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;

    logic [VAR_W-1:0]       w_var;
    logic [SLOT_W-1:0]      w_set;
    t_points                w_pts;
    logic signed [PT_W-1:0] w_x;
    t_op                    w_op;
    logic                   w_acc;
    logic                   w_load_ok;
    logic [ADDR_W-1:0]      w_waddr;
    logic [ADDR_W-1:0]      w_raddr;

    logic [VAR_W-1:0]       r_var;
    logic                   r_var_ok;
    logic signed [PT_W-1:0] r_x;
    logic [K_W-1:0]         r_k;
    logic                   r_cfg;
    logic [ENTRIES-1:0]     r_present;

    logic [63:0]            w_rdata;
    t_points                w_rp;

    logic                   r_div_start;
    logic [PT_W-1:0]        r_num;
    logic [PT_W-1:0]        r_den;
    logic                   w_div_done;
    logic [Q_W-1:0]         w_quot;

    logic [SLOT_W-1:0]      r_o_slot;
    logic                   r_o_cfg;
    logic [MEM_W-1:0]       r_o_mem;
    logic                   r_o_last;

    logic signed [PT_W:0]   w_xa;
    logic signed [PT_W:0]   w_ba;
    logic signed [PT_W:0]   w_dx;
    logic signed [PT_W:0]   w_dc;

    assign w_op  = t_op'(s_axis_tuser[0]);
    assign w_var = s_axis_tdata[1:0];
    assign w_set = s_axis_tdata[4:2];
    assign w_pts = t_points'(s_axis_tdata[68:5]);
    assign w_x   = s_axis_tdata[84:69];
    assign w_acc = s_axis_tvalid && s_axis_tready;

    assign w_load_ok = (int'(w_var) < NUM_INPUTS) && (int'(w_set) < NUM_SETS);
    assign w_waddr   = ADDR_W'(int'(w_var) * NUM_SETS + int'(w_set));
    assign w_raddr   = ADDR_W'(int'(r_var) * NUM_SETS + int'(r_k));

    tf_ram #(
        .WIDTH (64),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_acc && (w_op == OP_LOAD) && w_load_ok),
        .i_waddr (w_waddr),
        .i_wdata (w_pts),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rp = t_points'(w_rdata);

    tf_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // edge distances, widened by one bit so they cannot wrap
    assign w_xa = {r_x[PT_W-1], r_x} - {w_rp.a[PT_W-1], w_rp.a};
    assign w_ba = {w_rp.b[PT_W-1], w_rp.b} - {w_rp.a[PT_W-1], w_rp.a};
    assign w_dx = {w_rp.d[PT_W-1], w_rp.d} - {r_x[PT_W-1], r_x};
    assign w_dc = {w_rp.d[PT_W-1], w_rp.d} - {w_rp.c[PT_W-1], w_rp.c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= '0;
            r_div_start <= 1'b0;
            r_k         <= '0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (w_op == OP_LOAD) begin
                            if (w_load_ok) begin
                                r_present[w_waddr] <= 1'b1;
                            end
                        end else begin
                            r_var    <= w_var;
                            r_var_ok <= int'(w_var) < NUM_INPUTS;
                            r_x      <= w_x;
                            r_k      <= '0;
                            r_state  <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_cfg   <= r_var_ok && r_present[w_raddr];
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_o_slot <= SLOT_W'(r_k);
                    r_o_cfg  <= r_cfg;
                    r_o_last <= (int'(r_k) == NUM_SETS - 1);
                    r_o_mem  <= '0;
                    r_state  <= S_OUT;
                    if (r_cfg) begin
                        if (r_x >= w_rp.a && r_x < w_rp.b) begin
                            r_num       <= w_xa[PT_W-1:0];
                            r_den       <= w_ba[PT_W-1:0];
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end else if (r_x >= w_rp.b && r_x <= w_rp.c) begin
                            r_o_mem <= ONE_Q15;
                        end else if (r_x > w_rp.c && r_x <= w_rp.d) begin
                            r_num       <= w_dx[PT_W-1:0];
                            r_den       <= w_dc[PT_W-1:0];
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end else if (r_x > w_rp.d && w_rp.c == w_rp.d) begin
                            // right shoulder with a vertical edge stays at full
                            r_o_mem <= ONE_Q15;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_o_mem <= {1'b0, w_quot};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        if (int'(r_k) == NUM_SETS - 1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready   = (r_state == S_IDLE);
    assign m_axis_tvalid   = (r_state == S_OUT);
    assign m_axis_tdata    = {5'b00000, r_o_mem, r_o_slot};
    assign m_axis_tuser[0] = r_o_cfg;
    assign m_axis_tlast    = r_o_last;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while a result is pending");

    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (int'(r_k) == NUM_SETS - 1))
        else $error("tlast on a slot other than the final one");

    a_mem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[18:3] <= ONE_Q15))
        else $error("membership above one");

    a_unconf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[18:3] == '0))
        else $error("unconfigured slot with nonzero membership");

endmodule
